[rtl/sacl_pkg.sv]
// Shared types and constants for the set-associative LRU cache simulator.
// No dependencies; imported by every module of the block except sacl_ram.
package sacl_pkg;

  // Access kinds carried in the op field
  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

  localparam int CFG_DATA_W = 6;
  localparam int ADDR_W     = 64;
  // Offset and set index take at least one bit each
  localparam int TAG_W      = ADDR_W - 2;
  localparam int MAX_BLOCK_BITS = 32;

  // Input transaction
  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] address;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic        last_of_run;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_t;

  // Configuration registers
  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways_in_use;
    logic [5:0] block_bits;
  } cfg_t;

endpackage

[rtl/set_assoc_cache_lru_sim.sv]
// Top level of the set-associative LRU cache simulator: configuration
// registers, front end, back end. Uses sacl_pkg, sacl_front, sacl_back.
//
//   channel   signals                      moves
//   --------  ---------------------------  ---------------------------------
//   input     in_valid, in_ready, in_data  access kind + 64-bit address
//   output    out_valid, out_ready, out_data  hit/evict/last + running totals
//   config    cfg_we, cfg_index, cfg_data  register write, no handshake
//
// A load or store occupies the back end for a set read, then an update and
// write-back; a modify adds a second access that reuses the updated row.
// An instruction fetch is taken by the front end and produces nothing.
// The registered read of the set memory sets this sequence: one row read per
// queued transaction, one row write per result. A two-entry queue lets the front
// end keep accepting while the back end or the output stalls. After reset a clearing
// sweep over all 2**MAX_SET_BITS sets (64 by default) runs with in_ready held low.
module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cfg_t                    cfg;
  logic                    clearing;
  logic                    q_valid;
  logic                    q_pop;
  logic                    q_modify;
  logic [MAX_SET_BITS-1:0] q_set;
  logic [TAG_W-1:0]        q_tag;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits    <= 3'd1;
      cfg.ways_in_use <= 4'd1;
      cfg.block_bits  <= 6'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS:    cfg.set_bits    <= cfg_data[2:0];
        CFG_WAYS_IN_USE: cfg.ways_in_use <= cfg_data[3:0];
        CFG_BLOCK_BITS:  cfg.block_bits  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  sacl_front #(
    .MAX_SET_BITS(MAX_SET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_modify (q_modify),
    .q_set    (q_set),
    .q_tag    (q_tag)
  );

  sacl_back #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_modify  (q_modify),
    .q_set     (q_set),
    .q_tag     (q_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/sacl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/sacl_front.sv]
// Front end: accepts transactions, splits the address into set and tag,
// drops instruction fetches and queues accesses for the back end. Uses sacl_pkg.
module sacl_front
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    clearing,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_t                     in_data,
  output logic                    q_valid,
  input  logic                    q_pop,
  output logic                    q_modify,
  output logic [MAX_SET_BITS-1:0] q_set,
  output logic [TAG_W-1:0]        q_tag
);

  typedef struct packed {
    logic                    modify;
    logic [MAX_SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  logic [5:0]              sb;
  logic [5:0]              bb;
  logic [ADDR_W-1:0]       addr_sh;
  logic [ADDR_W-1:0]       tag_sh;
  logic [MAX_SET_BITS-1:0] set_mask;
  entry_t                  new_entry;
  entry_t                  q_mem [2];
  logic                    wr_ptr;
  logic                    rd_ptr;
  logic [1:0]              q_count;
  logic                    push;

  // Clamp the address split registers
  always_comb begin
    if (cfg.set_bits == 3'd0) begin
      sb = 6'd1;
    end else if (int'(cfg.set_bits) > MAX_SET_BITS) begin
      sb = 6'(MAX_SET_BITS);
    end else begin
      sb = {3'b0, cfg.set_bits};
    end
    if (cfg.block_bits == 6'd0) begin
      bb = 6'd1;
    end else if (int'(cfg.block_bits) > MAX_BLOCK_BITS) begin
      bb = 6'(MAX_BLOCK_BITS);
    end else begin
      bb = cfg.block_bits;
    end
  end

  // Address split into set index and tag
  always_comb begin
    addr_sh  = in_data.address >> bb;
    tag_sh   = in_data.address >> (7'(bb) + 7'(sb));
    set_mask = ~({MAX_SET_BITS{1'b1}} << sb);
    new_entry.modify  = (in_data.op == OP_MODIFY);
    new_entry.set_idx = addr_sh[MAX_SET_BITS-1:0] & set_mask;
    new_entry.tag     = tag_sh[TAG_W-1:0];
  end

  assign in_ready = !clearing && (q_count != 2'd2);
  assign push     = in_valid && in_ready && (in_data.op != OP_FETCH);

  // Two-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      q_count <= q_count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_entry;
    end
  end

  assign q_valid  = (q_count != 2'd0);
  assign q_modify = q_mem[rd_ptr].modify;
  assign q_set    = q_mem[rd_ptr].set_idx;
  assign q_tag    = q_mem[rd_ptr].tag;

endmodule

[rtl/sacl_back.sv]
// Back end: reads a set, resolves hit / fill / LRU eviction, writes the set
// back and presents results. Uses sacl_pkg and sacl_ram.
module sacl_back
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  output logic                    clearing,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic                    q_modify,
  input  logic [MAX_SET_BITS-1:0] q_set,
  input  logic [TAG_W-1:0]        q_tag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_t                    out_data
);

  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NSETS  = 1 << MAX_SET_BITS;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;

  typedef struct packed {
    logic              v;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;
  localparam int ROW_W = $bits(row_t);

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [MAX_SET_BITS-1:0] clr_idx;
  logic [MAX_SET_BITS-1:0] cur_set;
  logic [TAG_W-1:0]        cur_tag;
  logic                    cur_modify;
  row_t                    hold_row;
  logic [31:0]             hits_seen;
  logic [31:0]             misses_seen;
  logic [31:0]             evictions_seen;

  logic                    out_free;
  logic                    do_access;
  logic                    out_load;
  logic                    rd_en;
  logic                    ram_we;
  logic [MAX_SET_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        ram_rdata;

  row_t                    src_row;
  row_t                    new_row;
  logic [4:0]              nw;
  logic [MAX_WAYS-1:0]     used;
  logic [MAX_WAYS-1:0]     match;
  logic [MAX_WAYS-1:0]     inval;
  logic [WAY_W-1:0]        hit_way;
  logic [WAY_W-1:0]        inv_way;
  logic [WAY_W-1:0]        best_way;
  logic [RANK_W-1:0]       best_rank;
  logic [RANK_W-1:0]       hit_rank;
  logic [WAY_W-1:0]        target;
  logic                    acc_hit;
  logic                    acc_evict;

  // Set storage: one row per set, all ways side by side
  sacl_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NSETS)
  ) u_sets (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(q_set),
    .rdata(ram_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign rd_en     = (state == ST_IDLE) && !clearing && q_valid && out_free;
  assign q_pop     = rd_en;
  assign do_access = (state == ST_LOOK) || ((state == ST_SECOND) && out_free);
  assign out_load  = do_access;

  // Clamp the way count and mark used ways
  always_comb begin
    if (cfg.ways_in_use == 4'd0) begin
      nw = 5'd1;
    end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
      nw = 5'(MAX_WAYS);
    end else begin
      nw = {1'b0, cfg.ways_in_use};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      used[w] = (5'(w) < nw);
    end
  end

  // Lookup: hit way, first invalid way, LRU victim
  always_comb begin
    src_row = (state == ST_SECOND) ? hold_row : row_t'(ram_rdata);
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = used[w] && src_row[w].v && (src_row[w].tag == cur_tag);
      inval[w] = used[w] && !src_row[w].v;
    end
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (inval[w]) begin
        inv_way = WAY_W'(w);
      end
    end
    // Highest rank wins, lowest way on a tie
    best_way  = '0;
    best_rank = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (used[w] && (src_row[w].rank > best_rank)) begin
        best_rank = src_row[w].rank;
        best_way  = WAY_W'(w);
      end
    end
    acc_hit   = |match;
    acc_evict = !acc_hit && !(|inval);
    hit_rank  = src_row[hit_way].rank;
    if (acc_hit) begin
      target = hit_way;
    end else if (!acc_evict) begin
      target = inv_way;
    end else begin
      target = best_way;
    end
  end

  // Rank aging and target refill
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_row[w] = src_row[w];
      if (WAY_W'(w) == target) begin
        new_row[w].v    = 1'b1;
        new_row[w].tag  = cur_tag;
        new_row[w].rank = '0;
      end else if (used[w] && src_row[w].v && (!acc_hit || (src_row[w].rank < hit_rank)) &&
                   (src_row[w].rank < RANK_MAX)) begin
        new_row[w].rank = src_row[w].rank + 1'b1;
      end
    end
  end

  // Write port: clearing sweep after reset, else access write-back
  always_comb begin
    ram_we    = clearing || do_access;
    ram_waddr = clearing ? clr_idx : cur_set;
    ram_wdata = clearing ? '0 : ROW_W'(new_row);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_en) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = cur_modify ? ST_SECOND : ST_IDLE;
      end
      ST_SECOND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      clearing       <= 1'b1;
      clr_idx        <= '0;
      hits_seen      <= '0;
      misses_seen    <= '0;
      evictions_seen <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == {MAX_SET_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      if (do_access) begin
        if (acc_hit) begin
          hits_seen <= hits_seen + 32'd1;
        end else begin
          misses_seen <= misses_seen + 32'd1;
        end
        if (acc_evict) begin
          evictions_seen <= evictions_seen + 32'd1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_set    <= q_set;
      cur_tag    <= q_tag;
      cur_modify <= q_modify;
    end
    if (state == ST_LOOK) begin
      hold_row <= new_row;
    end
    if (out_load) begin
      out_data.hit            <= acc_hit;
      out_data.evicted        <= acc_evict;
      out_data.last_of_run    <= (state == ST_SECOND) || !cur_modify;
      out_data.hit_total      <= hits_seen + 32'(acc_hit);
      out_data.miss_total     <= misses_seen + 32'(!acc_hit);
      out_data.eviction_total <= evictions_seen + 32'(acc_evict);
    end
  end

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // The sweep owns the memory; no lookup starts during it
  a_no_read_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !rd_en)
    else $error("set read during clearing sweep");

  // Output slot is empty when the looked-up row arrives
  a_look_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> !out_valid)
    else $error("output slot busy at lookup");

  // Each access counts exactly one hit or one miss
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ((hits_seen + misses_seen) == ($past(hits_seen) + $past(misses_seen) + 32'd1)))
    else $error("hit/miss totals out of step");

  // An eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.hit && out_data.evicted))
    else $error("eviction reported on a hit");

endmodule

[tb/set_assoc_cache_lru_sim_tb.sv]
// Self-checking testbench for the set-associative LRU cache simulator.
// Depends on every file under rtl/ (package, RAM, front end, back end, top); runs alone.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_tb;
  import sacl_pkg::*;

  localparam int SET_BITS_MAX    = 6;
  localparam int WAYS_MAX        = 8;
  localparam int LINE_COUNT      = (1 << SET_BITS_MAX) * WAYS_MAX;
  localparam int DRAIN_CYCLES    = 16;
  localparam int RAND_PHASES     = 11;
  localparam int ITEMS_PER_PHASE = 148;
  localparam int TAG_POOL        = 12;
  localparam int HOLD_AT         = 400;
  localparam int HOLD_CYCLES     = 300;
  localparam int LIMIT_CYCLES    = 500000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;

  set_assoc_cache_lru_sim #(
    .MAX_SET_BITS(SET_BITS_MAX),
    .MAX_WAYS(WAYS_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Shadow copy of the cache contents and registers
  logic [2:0]       reg_set_bits;
  logic [3:0]       reg_ways;
  logic [5:0]       reg_block_bits;
  logic             way_valid [LINE_COUNT];
  logic [TAG_W-1:0] way_tag [LINE_COUNT];
  logic [2:0]       way_age [LINE_COUNT];
  logic [31:0]      hits_pred;
  logic [31:0]      misses_pred;
  logic [31:0]      evict_count;

  // Access outcomes still owed by the block, oldest first
  out_t access_outcomes [$];

  int   mismatches;
  int   accesses_sent;
  int   results_checked;
  int   settings_used;
  int   cycle_count;
  logic [63:0] tag_pool [TAG_POOL];

  // Directed stimulus table
  typedef struct {
    bit         is_cfg;
    logic [5:0] c_sb;
    logic [5:0] c_ways;
    logic [5:0] c_bb;
    in_t        item;
    bit         typed;
    out_t       want;
  } row_t;
  row_t directed [$];

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One cache lookup with LRU update; returns the outcome it produces
  function automatic out_t lru_access(logic [63:0] addr, logic last);
    int sb, nw, bb, base, target, limit, best, best_rank, w, i;
    logic [63:0] tag;
    logic hit, evict;
    out_t res;
    sb = clamp_to(int'(reg_set_bits), 1, SET_BITS_MAX);
    nw = clamp_to(int'(reg_ways), 1, WAYS_MAX);
    bb = clamp_to(int'(reg_block_bits), 1, MAX_BLOCK_BITS);
    base = int'((addr >> bb) & ((64'd1 << sb) - 64'd1)) * WAYS_MAX;
    tag = addr >> (bb + sb);
    target = nw;
    hit = 1'b0;
    evict = 1'b0;
    for (w = 0; w < nw; w++) begin
      if (!hit && way_valid[base + w] && way_tag[base + w] == tag[TAG_W-1:0]) begin
        target = w;
        hit = 1'b1;
      end
    end
    if (hit) begin
      hits_pred++;
      limit = int'(way_age[base + target]);
    end else begin
      misses_pred++;
      limit = WAYS_MAX + 1;
      // first free way, else the oldest one (lowest way on a tie)
      for (w = 0; w < nw; w++)
        if (target == nw && !way_valid[base + w]) target = w;
      if (target == nw) begin
        best = 0;
        best_rank = 0;
        for (w = 0; w < nw; w++) begin
          if (int'(way_age[base + w]) > best_rank) begin
            best_rank = int'(way_age[base + w]);
            best = w;
          end
        end
        target = best;
        evict = 1'b1;
        evict_count++;
      end
    end
    // age the other lines, saturating at the oldest rank
    for (w = 0; w < nw; w++) begin
      i = base + w;
      if (w != target && way_valid[i] && int'(way_age[i]) < limit &&
          int'(way_age[i]) < WAYS_MAX - 1)
        way_age[i] = way_age[i] + 3'd1;
    end
    way_valid[base + target] = 1'b1;
    way_tag[base + target] = tag[TAG_W-1:0];
    way_age[base + target] = 3'd0;
    res.hit = hit;
    res.evicted = evict;
    res.last_of_run = last;
    res.hit_total = hits_pred;
    res.miss_total = misses_pred;
    res.eviction_total = evict_count;
    return res;
  endfunction

  // Queue the outcomes of one accepted transaction
  function automatic void apply_access(in_t item, bit typed, out_t want);
    out_t r;
    case (item.op)
      OP_FETCH: ;
      OP_MODIFY: begin
        access_outcomes.push_back(lru_access(item.address, 1'b0));
        access_outcomes.push_back(lru_access(item.address, 1'b1));
      end
      default: begin
        r = lru_access(item.address, 1'b1);
        access_outcomes.push_back(typed ? want : r);
      end
    endcase
  endfunction

  function automatic void add_cfg(logic [5:0] sb, logic [5:0] ways, logic [5:0] bb);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.c_sb = sb;
    r.c_ways = ways;
    r.c_bb = bb;
    directed.push_back(r);
  endfunction

  function automatic void add_acc(logic [1:0] op, logic [63:0] addr);
    row_t r;
    r = '{default: '0};
    r.item.op = op;
    r.item.address = addr;
    directed.push_back(r);
  endfunction

  function automatic void add_checked(logic [1:0] op, logic [63:0] addr, logic hit,
                                      logic ev, int hits, int misses, int evs);
    row_t r;
    r = '{default: '0};
    r.item.op = op;
    r.item.address = addr;
    r.typed = 1'b1;
    r.want.hit = hit;
    r.want.evicted = ev;
    r.want.last_of_run = 1'b1;
    r.want.hit_total = hits;
    r.want.miss_total = misses;
    r.want.eviction_total = evs;
    directed.push_back(r);
  endfunction

  // Random address: mostly a small tag pool over a few sets, sometimes noise
  function automatic logic [63:0] make_address();
    int sb, bb, nw, top_set;
    logic [63:0] a, set_idx, tag;
    a = {$urandom, $urandom};
    sb = clamp_to(int'(reg_set_bits), 1, SET_BITS_MAX);
    bb = clamp_to(int'(reg_block_bits), 1, MAX_BLOCK_BITS);
    nw = clamp_to(int'(reg_ways), 1, WAYS_MAX);
    if ($urandom_range(0, 7) == 0) return a;
    top_set = ($urandom_range(0, 3) == 0 || (1 << sb) < 4) ? (1 << sb) - 1 : 3;
    set_idx = 64'($urandom_range(0, top_set));
    tag = tag_pool[$urandom_range(0, clamp_to(nw + 2, 0, TAG_POOL - 1))];
    return (tag << (bb + sb)) | (set_idx << bb) | (a & ((64'd1 << bb) - 64'd1));
  endfunction

  // Send one transaction after a random gap; predict once it is taken
  task automatic send_access(in_t item, bit typed, out_t want);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    apply_access(item, typed, want);
    accesses_sent++;
  endtask

  // Let the block go idle, then write all three registers
  task automatic program_regs(logic [5:0] sb, logic [5:0] ways, logic [5:0] bb);
    in_valid <= 1'b0;
    while (access_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SET_BITS;
    cfg_data <= sb;
    @(posedge clk);
    cfg_index <= CFG_WAYS_IN_USE;
    cfg_data <= ways;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_BITS;
    cfg_data <= bb;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_set_bits = sb[2:0];
    reg_ways = ways[3:0];
    reg_block_bits = bb;
    settings_used++;
  endtask

  // Result side: random stalls, one long hold-off, compare against the oldest outcome
  initial begin
    int gap;
    bit held;
    out_t got, want;
    out_ready = 1'b0;
    held = 1'b0;
    forever begin
      if (results_checked == HOLD_AT && !held) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end else begin
        gap = $urandom_range(0, 13);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = out_data;
      @(posedge clk);
      results_checked++;
      if (access_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hit=%0b ev=%0b last=%0b totals=%0d/%0d/%0d",
                   got.hit, got.evicted, got.last_of_run, got.hit_total,
                   got.miss_total, got.eviction_total);
      end else begin
        want = access_outcomes.pop_front();
        if (got.hit !== want.hit || got.evicted !== want.evicted ||
            got.last_of_run !== want.last_of_run || got.hit_total !== want.hit_total ||
            got.miss_total !== want.miss_total ||
            got.eviction_total !== want.eviction_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp hit=%0b ev=%0b last=%0b totals=%0d/%0d/%0d, got hit=%0b ev=%0b last=%0b totals=%0d/%0d/%0d",
                     results_checked, want.hit, want.evicted, want.last_of_run,
                     want.hit_total, want.miss_total, want.eviction_total,
                     got.hit, got.evicted, got.last_of_run,
                     got.hit_total, got.miss_total, got.eviction_total);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("set_assoc_cache_lru_sim test failed");
    $finish;
  end

  // Stimulus
  initial begin
    int ph, k;
    in_t item;
    out_t none;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SET_BITS;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    none = '0;
    mismatches = 0;
    accesses_sent = 0;
    results_checked = 0;
    settings_used = 0;
    reg_set_bits = 3'd1;
    reg_ways = 4'd1;
    reg_block_bits = 6'd5;
    for (k = 0; k < LINE_COUNT; k++) begin
      way_valid[k] = 1'b0;
      way_tag[k] = '0;
      way_age[k] = '0;
    end
    hits_pred = '0;
    misses_pred = '0;
    evict_count = '0;

    // Reset-time settings: one way, two sets, 32-byte blocks
    add_checked(OP_LOAD, 64'd0, 1'b0, 1'b0, 0, 1, 0);
    add_checked(OP_STORE, 64'd0, 1'b1, 1'b0, 1, 1, 0);
    add_acc(OP_FETCH, 64'd0);
    add_checked(OP_LOAD, 64'd64, 1'b0, 1'b1, 1, 2, 1);
    add_acc(OP_MODIFY, '1);
    // Registers above range: clamp to 64 sets, 8 ways, 32 offset bits
    add_cfg(6'd7, 6'd15, 6'd63);
    for (k = 0; k < WAYS_MAX; k++) add_acc(OP_STORE, 64'(k) << 38);
    add_acc(OP_LOAD, 64'd3 << 38);      // hit in the middle of the age order
    add_acc(OP_MODIFY, 64'd8 << 38);    // evict the oldest, then hit
    add_acc(OP_LOAD, 64'd0);            // evict again
    add_acc(OP_LOAD, '1);
    add_acc(OP_LOAD, 64'h0000_0000_FFFF_FFFF);
    // Registers at zero: clamp to the minimum split
    add_cfg(6'd0, 6'd0, 6'd0);
    add_acc(OP_LOAD, 64'd0);
    add_acc(OP_LOAD, 64'd2);
    add_acc(OP_MODIFY, 64'd6);
    add_acc(OP_STORE, 64'h8000_0000_0000_0001);
    // Back to the wide split: lines written before are still there
    add_cfg(6'd7, 6'd15, 6'd63);
    add_acc(OP_LOAD, 64'd3 << 38);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed[k]) begin
      if (directed[k].is_cfg)
        program_regs(directed[k].c_sb, directed[k].c_ways, directed[k].c_bb);
      else
        send_access(directed[k].item, directed[k].typed, directed[k].want);
    end

    // Random phases, extremes first
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: program_regs(6'd7, 6'd15, 6'd63);
        1: program_regs(6'd0, 6'd0, 6'd0);
        2: program_regs(6'd6, 6'd8, 6'd32);
        3: program_regs(6'd1, 6'd1, 6'd1);
        default: program_regs(6'($urandom_range(0, 7)), 6'($urandom_range(0, 15)),
                              6'($urandom_range(0, 63)));
      endcase
      for (k = 0; k < TAG_POOL; k++) tag_pool[k] = {$urandom, $urandom};
      repeat (ITEMS_PER_PHASE) begin
        item.op = ($urandom_range(0, 9) == 0) ? OP_FETCH : 2'($urandom_range(1, 3));
        item.address = make_address();
        send_access(item, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (access_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d accesses under %0d register settings; %0d results checked",
             accesses_sent, settings_used, results_checked);
    $display("Model totals: %0d hits, %0d misses, %0d evictions; %0d mismatches",
             hits_pred, misses_pred, evict_count, mismatches);
    if (mismatches == 0 && access_outcomes.size() == 0)
      $display("set_assoc_cache_lru_sim test passed");
    else
      $display("set_assoc_cache_lru_sim test failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_front.sv
rtl/sacl_back.sv
rtl/set_assoc_cache_lru_sim.sv
tb/set_assoc_cache_lru_sim_tb.sv
